/* rtl/tce_pkg.sv */
// Shared types and constants for the text charset encoder.
// Holds the job descriptor passed from front to back and the character code functions.
// No dependencies.
package tce_pkg;

    localparam logic [7:0] CH_BRACE_OPEN  = 8'h7B;
    localparam logic [7:0] CH_BRACE_CLOSE = 8'h7D;
    localparam logic [7:0] CH_ZERO        = 8'h30;
    localparam logic [7:0] CH_X_LOWER     = 8'h78;
    localparam logic [7:0] TERMINATOR     = 8'h00;

    localparam logic [2:0] PROG_IDLE  = 3'd0;
    localparam logic [2:0] PROG_BRACE = 3'd1;
    localparam logic [2:0] PROG_ZERO  = 3'd2;
    localparam logic [2:0] PROG_X     = 3'd3;
    localparam logic [2:0] PROG_HEX1  = 3'd4;
    localparam logic [2:0] PROG_HEX2  = 3'd5;

    // One accepted item, reduced to what the back end must emit:
    // flush of the open escape, then one code, then a lone fallback, then terminator.
    typedef struct packed {
        logic [2:0] count;
        logic [2:0] flush_len;
        logic [7:0] digit0;
        logic [7:0] digit1;
        logic       mid_valid;
        logic [7:0] mid_code;
        logic       extra_fb;
    } t_job;

    function automatic logic [7:0] sym_code(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h20: r = 8'h01;  8'h0A: r = 8'h02;  8'h2D: r = 8'h54;  8'h21: r = 8'h48;
            8'h3F: r = 8'h49;  8'h25: r = 8'h4A;  8'h2F: r = 8'h4B;  8'h2E: r = 8'h4F;
            8'h2C: r = 8'h50;  8'h3B: r = 8'h51;  8'h3A: r = 8'h52;  8'h27: r = 8'h57;
            8'h28: r = 8'h5A;  8'h29: r = 8'h5B;  8'h5B: r = 8'h62;  8'h5D: r = 8'h63;
            8'hE0: r = 8'hB7;  8'hE1: r = 8'hB8;  8'hE2: r = 8'hB9;  8'hE4: r = 8'hBA;
            8'hE8: r = 8'hBB;  8'hE9: r = 8'hBC;  8'hEA: r = 8'hBD;  8'hEB: r = 8'hBE;
            8'hEC: r = 8'hBF;  8'hED: r = 8'hC0;  8'hEE: r = 8'hC1;  8'hEF: r = 8'hC2;
            8'hF1: r = 8'hC3;  8'hF2: r = 8'hC4;  8'hF3: r = 8'hC5;  8'hF4: r = 8'hC6;
            8'hF6: r = 8'hC7;  8'hF9: r = 8'hC8;  8'hFA: r = 8'hC9;  8'hFB: r = 8'hCA;
            8'hFC: r = 8'hCB;  8'hE7: r = 8'hE8;  8'hC0: r = 8'hD0;  8'hC1: r = 8'hD1;
            8'hC2: r = 8'hD2;  8'hC4: r = 8'hD3;  8'hC8: r = 8'hD4;  8'hC9: r = 8'hD5;
            8'hCA: r = 8'hD6;  8'hCB: r = 8'hD7;  8'hCC: r = 8'hD8;  8'hCD: r = 8'hD9;
            8'hCE: r = 8'hDA;  8'hCF: r = 8'hDB;  8'hD1: r = 8'hDC;  8'hD2: r = 8'hDD;
            8'hD3: r = 8'hDE;  8'hD4: r = 8'hDF;  8'hD6: r = 8'hE0;  8'hD9: r = 8'hE1;
            8'hDA: r = 8'hE2;  8'hDB: r = 8'hE3;  8'hDC: r = 8'hE4;  8'hA1: r = 8'hE5;
            8'hBF: r = 8'hE6;  8'hC7: r = 8'hE7;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] plain_code(input logic [7:0] c, input logic [7:0] fb);
        logic [7:0] s;
        logic [7:0] r;
        s = sym_code(c);
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c + 8'h39;
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            r = c - 8'h13;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = c + 8'h60;
        end else if (s != 8'h00) begin
            r = s;
        end else begin
            r = fb;
        end
        return r;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    // Valid only for hex digit characters; letters have bit 6 set.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        return c[6] ? (c[3:0] + 4'd9) : c[3:0];
    endfunction

endpackage

/* rtl/tce_front.sv */
// Front end: accepts text beats, tracks the hex escape parser state and
// builds one job descriptor per beat. Depends on tce_pkg.
module tce_front import tce_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_text_byte,
    input  logic       i_byte_present,
    input  logic       i_end_of_text,
    input  logic [7:0] i_fallback,
    output logic       o_push,
    output t_job       o_job
);

    logic [2:0] r_prog;
    logic [2:0] n_prog;
    logic [7:0] r_digit0;
    logic [7:0] n_digit0;
    logic [7:0] r_digit1;
    logic [7:0] n_digit1;

    logic       in_esc;
    logic       ok;
    logic       fail;
    logic       mid_valid;
    logic [7:0] mid_code;
    logic [2:0] flush_len;
    logic       extra_fb;
    logic [2:0] count;

    always_comb begin
        in_esc = (r_prog >= PROG_BRACE) && (r_prog <= PROG_HEX2);
        unique case (r_prog)
            PROG_BRACE: ok = (i_text_byte == CH_ZERO);
            PROG_ZERO:  ok = (i_text_byte == CH_X_LOWER);
            PROG_X:     ok = is_hex(i_text_byte);
            PROG_HEX1:  ok = is_hex(i_text_byte);
            PROG_HEX2:  ok = (i_text_byte == CH_BRACE_CLOSE);
            default:    ok = 1'b0;
        endcase
        fail = i_byte_present && in_esc && !ok;

        n_prog    = r_prog;
        n_digit0  = r_digit0;
        n_digit1  = r_digit1;
        mid_valid = 1'b0;
        mid_code  = 8'h00;
        if (i_byte_present) begin
            if (!in_esc || fail) begin
                if (i_text_byte == CH_BRACE_OPEN) begin
                    n_prog = PROG_BRACE;
                end else begin
                    n_prog    = PROG_IDLE;
                    mid_valid = 1'b1;
                    mid_code  = plain_code(i_text_byte, i_fallback);
                end
            end else begin
                if (r_prog == PROG_X) begin
                    n_digit0 = i_text_byte;
                end
                if (r_prog == PROG_HEX1) begin
                    n_digit1 = i_text_byte;
                end
                if (r_prog == PROG_HEX2) begin
                    mid_valid = 1'b1;
                    mid_code  = {hex_val(r_digit0), hex_val(r_digit1)};
                    n_prog    = PROG_IDLE;
                end else begin
                    n_prog = r_prog + 3'd1;
                end
            end
        end

        if (fail) begin
            flush_len = r_prog;
            extra_fb  = i_end_of_text && (n_prog == PROG_BRACE);
        end else begin
            flush_len = (i_end_of_text && n_prog >= PROG_BRACE && n_prog <= PROG_HEX2) ?
                        n_prog : 3'd0;
            extra_fb  = 1'b0;
        end

        count = flush_len + {2'b00, mid_valid} + {2'b00, extra_fb} + {2'b00, i_end_of_text};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog <= PROG_IDLE;
        end else if (i_accept) begin
            r_prog <= i_end_of_text ? PROG_IDLE : n_prog;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_digit0 <= n_digit0;
            r_digit1 <= n_digit1;
        end
    end

    assign o_push          = i_accept && (count != 3'd0);
    assign o_job.count     = count;
    assign o_job.flush_len = flush_len;
    assign o_job.digit0    = n_digit0;
    assign o_job.digit1    = n_digit1;
    assign o_job.mid_valid = mid_valid;
    assign o_job.mid_code  = mid_code;
    assign o_job.extra_fb  = extra_fb;

endmodule

/* rtl/tce_queue.sv */
// Short job queue between front and back end.
// Depends on tce_pkg for the job type.
module tce_queue import tce_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

/* rtl/tce_back.sv */
// Back end: walks the head job one code per cycle, unless stalled, into a registered
// output beat. Depends on tce_pkg.
module tce_back import tce_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    input  logic [7:0] i_fallback,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_code_byte,
    output logic       o_last_of_run
);

    logic [2:0] r_idx;
    logic       r_valid;
    logic [7:0] r_code;
    logic       r_last;

    logic       advance;
    logic       last;
    logic [7:0] code;
    logic [2:0] rel;
    logic [2:0] rel2;

    always_comb begin
        rel  = r_idx - i_job.flush_len;
        rel2 = rel - {2'b00, i_job.mid_valid};
        code = TERMINATOR;
        if (r_idx < i_job.flush_len) begin
            case (r_idx)
                3'd0:    code = i_fallback;
                3'd1:    code = plain_code(CH_ZERO, i_fallback);
                3'd2:    code = plain_code(CH_X_LOWER, i_fallback);
                3'd3:    code = plain_code(i_job.digit0, i_fallback);
                default: code = plain_code(i_job.digit1, i_fallback);
            endcase
        end else if (i_job.mid_valid && rel == 3'd0) begin
            code = i_job.mid_code;
        end else if (i_job.extra_fb && rel2 == 3'd0) begin
            code = i_fallback;
        end
    end

    assign last    = (r_idx == i_job.count - 3'd1);
    assign advance = i_job_valid && (!r_valid || i_ready);
    assign o_pop   = advance && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else begin
            if (advance) begin
                r_valid <= 1'b1;
                r_idx   <= last ? 3'd0 : r_idx + 3'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_code <= code;
            r_last <= last;
        end
    end

    assign o_valid       = r_valid;
    assign o_code_byte   = r_code;
    assign o_last_of_run = r_last;

endmodule

/* rtl/text_charset_encoder_with_hex_escape.sv */
// Text charset encoder with hex escape: front parser, job queue, back emitter.
// Beats that yield codes are queued as jobs; the back end registers each code beat.
// Throughput: one text beat per cycle while the queue has room; the back end emits
// one code per cycle unless stalled, a beat's codes in turn (queue absorbs bursts).
// Reset: escape parser idle, queue and output empty, fallback code set to 0x01.
module text_charset_encoder_with_hex_escape import tce_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_byte_present,
    input  logic       i_end_of_text,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_code_byte,
    output logic       o_last_of_run,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data
);

    logic [7:0] r_fallback;
    logic       accept;
    logic       push;
    logic       full;
    logic       pop;
    logic       head_valid;
    t_job       job_in;
    t_job       job_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fallback <= 8'h01;
        end else if (i_cfg_wr_en) begin
            r_fallback <= i_cfg_wr_data;
        end
    end

    assign o_ready = !full;
    assign accept  = i_valid && o_ready;

    tce_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_text_byte    (i_text_byte),
        .i_byte_present (i_byte_present),
        .i_end_of_text  (i_end_of_text),
        .i_fallback     (r_fallback),
        .o_push         (push),
        .o_job          (job_in)
    );

    tce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_head  (job_head)
    );

    tce_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (head_valid),
        .i_job         (job_head),
        .i_fallback    (r_fallback),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_code_byte   (o_code_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule

/* sim/text_charset_encoder_with_hex_escape_tb.sv */
// Self-checking testbench for text_charset_encoder_with_hex_escape: queued text beats with
// random gaps, a code monitor with random stalls, and an in-bench encoder that predicts codes.
// Depends on tce_pkg and the top-level RTL only.
module text_charset_encoder_with_hex_escape_tb;
    import tce_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 55;

    typedef struct packed {
        logic [7:0] text;
        logic       present;
        logic       eot;
    } t_text_item;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_code_beat;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_text_byte = 8'h00;
    logic       i_byte_present = 1'b0;
    logic       i_end_of_text = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_code_byte;
    logic       o_last_of_run;
    logic       i_cfg_wr_en = 1'b0;
    logic [7:0] i_cfg_wr_data = 8'h00;

    t_text_item text_items[$];
    t_code_beat pending_codes[$];
    logic [7:0] run_codes[$];

    // encoder state as the testbench sees it
    logic [7:0] fb_code = 8'h01;
    logic [2:0] esc_step = PROG_IDLE;
    logic [7:0] esc_digits[2];

    int         item_count = 0;
    int         mismatches = 0;
    int         cycle_count = 0;

    t_text_item cur_item = '0;
    bit         drv_busy = 1'b0;
    bit         drv_no_idle = 1'b0;
    int         drv_gap = 0;
    bit         mon_no_idle = 1'b0;
    int         mon_stall = 0;

    text_charset_encoder_with_hex_escape u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_text_byte    (i_text_byte),
        .i_byte_present (i_byte_present),
        .i_end_of_text  (i_end_of_text),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_code_byte    (o_code_byte),
        .o_last_of_run  (o_last_of_run),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] latin_sym(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h20: r = 8'h01;  8'h0A: r = 8'h02;  8'h2D: r = 8'h54;  8'h21: r = 8'h48;
            8'h3F: r = 8'h49;  8'h25: r = 8'h4A;  8'h2F: r = 8'h4B;  8'h2E: r = 8'h4F;
            8'h2C: r = 8'h50;  8'h3B: r = 8'h51;  8'h3A: r = 8'h52;  8'h27: r = 8'h57;
            8'h28: r = 8'h5A;  8'h29: r = 8'h5B;  8'h5B: r = 8'h62;  8'h5D: r = 8'h63;
            8'hA1: r = 8'hE5;  8'hBF: r = 8'hE6;  8'hC7: r = 8'hE7;  8'hE7: r = 8'hE8;
            8'hC0: r = 8'hD0;  8'hC1: r = 8'hD1;  8'hC2: r = 8'hD2;  8'hC4: r = 8'hD3;
            8'hC8: r = 8'hD4;  8'hC9: r = 8'hD5;  8'hCA: r = 8'hD6;  8'hCB: r = 8'hD7;
            8'hCC: r = 8'hD8;  8'hCD: r = 8'hD9;  8'hCE: r = 8'hDA;  8'hCF: r = 8'hDB;
            8'hD1: r = 8'hDC;  8'hD2: r = 8'hDD;  8'hD3: r = 8'hDE;  8'hD4: r = 8'hDF;
            8'hD6: r = 8'hE0;  8'hD9: r = 8'hE1;  8'hDA: r = 8'hE2;  8'hDB: r = 8'hE3;
            8'hDC: r = 8'hE4;  8'hE0: r = 8'hB7;  8'hE1: r = 8'hB8;  8'hE2: r = 8'hB9;
            8'hE4: r = 8'hBA;  8'hE8: r = 8'hBB;  8'hE9: r = 8'hBC;  8'hEA: r = 8'hBD;
            8'hEB: r = 8'hBE;  8'hEC: r = 8'hBF;  8'hED: r = 8'hC0;  8'hEE: r = 8'hC1;
            8'hEF: r = 8'hC2;  8'hF1: r = 8'hC3;  8'hF2: r = 8'hC4;  8'hF3: r = 8'hC5;
            8'hF4: r = 8'hC6;  8'hF6: r = 8'hC7;  8'hF9: r = 8'hC8;  8'hFA: r = 8'hC9;
            8'hFB: r = 8'hCA;  8'hFC: r = 8'hCB;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] char_code(input logic [7:0] c);
        logic [7:0] s;
        s = latin_sym(c);
        if (c >= "a" && c <= "z") return c + 8'h39;
        if (c >= "A" && c <= "Z") return c - 8'h13;
        if (c >= "0" && c <= "9") return c + 8'h60;
        if (s != 8'h00) return s;
        return fb_code;
    endfunction

    function automatic logic is_hex_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        if (c <= "9") v = c - "0";
        else if (c >= "a") v = c - "a" + 8'd10;
        else v = c - "A" + 8'd10;
        return v[3:0];
    endfunction

    function automatic logic [7:0] rand_hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) return 8'(v) + "0";
        if ($urandom_range(0, 1) == 1) return 8'(v - 10) + "a";
        return 8'(v - 10) + "A";
    endfunction

    task automatic append_code(input logic [7:0] c);
        run_codes.insert(run_codes.size(), c);
    endtask

    // open escape gives up: fallback for the brace, then the held bytes as plain text
    task automatic flush_escape();
        if (esc_step >= PROG_BRACE && esc_step <= PROG_HEX2) begin
            append_code(fb_code);
            if (esc_step >= PROG_ZERO) append_code(char_code(CH_ZERO));
            if (esc_step >= PROG_X) append_code(char_code(CH_X_LOWER));
            if (esc_step >= PROG_HEX1) append_code(char_code(esc_digits[0]));
            if (esc_step >= PROG_HEX2) append_code(char_code(esc_digits[1]));
        end
        esc_step = PROG_IDLE;
    endtask

    task automatic encode_beat(input t_text_item it);
        logic cont;
        run_codes = {};
        if (it.present) begin
            if (esc_step == PROG_IDLE || esc_step > PROG_HEX2) begin
                esc_step = PROG_IDLE;
                if (it.text == CH_BRACE_OPEN) esc_step = PROG_BRACE;
                else append_code(char_code(it.text));
            end else begin
                case (esc_step)
                    PROG_BRACE: cont = (it.text == CH_ZERO);
                    PROG_ZERO: cont = (it.text == CH_X_LOWER);
                    PROG_X, PROG_HEX1: cont = is_hex_char(it.text);
                    default: cont = (it.text == CH_BRACE_CLOSE);
                endcase
                if (!cont) begin
                    flush_escape();
                    if (it.text == CH_BRACE_OPEN) esc_step = PROG_BRACE;
                    else append_code(char_code(it.text));
                end else if (esc_step == PROG_HEX2) begin
                    append_code({hex_nibble(esc_digits[0]), hex_nibble(esc_digits[1])});
                    esc_step = PROG_IDLE;
                end else begin
                    if (esc_step == PROG_X) esc_digits[0] = it.text;
                    if (esc_step == PROG_HEX1) esc_digits[1] = it.text;
                    esc_step = esc_step + 3'd1;
                end
            end
        end
        if (it.eot) begin
            flush_escape();
            append_code(TERMINATOR);
        end
        for (int i = 0; i < run_codes.size(); i++) begin
            pending_codes.insert(pending_codes.size(),
                                 '{code: run_codes[i], last: (i == run_codes.size() - 1)});
        end
    endtask

    task automatic add_item(input logic [7:0] t, input logic p, input logic e);
        text_items.insert(text_items.size(), '{text: t, present: p, eot: e});
        if (p || e) item_count++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_item(s[i], 1'b1, 1'b0);
    endtask

    task automatic wait_drained();
        while (text_items.size() != 0 || drv_busy || pending_codes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_busy = 1'b0;
            drv_gap = 0;
        end else begin
            if (drv_busy && o_ready) begin
                encode_beat(cur_item);
                drv_busy = 1'b0;
                if ($urandom_range(0, 29) == 0) drv_no_idle = !drv_no_idle;
                drv_gap = drv_no_idle ? 0 : $urandom_range(0, 12);
            end
            if (!drv_busy) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                end else if (text_items.size() != 0) begin
                    cur_item = text_items.pop_front();
                    drv_busy = 1'b1;
                end
            end
        end
        i_valid        <= drv_busy;
        i_text_byte    <= cur_item.text;
        i_byte_present <= cur_item.present;
        i_end_of_text  <= cur_item.eot;
    end

    // monitor
    always @(posedge i_clk) begin
        t_code_beat exp_beat;
        if (!i_rst_n) begin
            mon_stall = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (pending_codes.size() == 0) begin
                    $error("code beat with nothing expected: code_byte %h last_of_run %b",
                           o_code_byte, o_last_of_run);
                    mismatches++;
                end else begin
                    exp_beat = pending_codes.pop_front();
                    if (o_code_byte !== exp_beat.code) begin
                        $error("code_byte mismatch: expected %h, actual %h",
                               exp_beat.code, o_code_byte);
                        mismatches++;
                    end
                    if (o_last_of_run !== exp_beat.last) begin
                        $error("last_of_run mismatch: expected %b, actual %b",
                               exp_beat.last, o_last_of_run);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 29) == 0) mon_no_idle = !mon_no_idle;
                mon_stall = mon_no_idle ? 0 : $urandom_range(0, 12);
            end else if (mon_stall > 0) begin
                mon_stall--;
            end
        end
        i_ready <= i_rst_n && (mon_stall == 0);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [7:0] fb_values[4];
        int         target;
        int         len;
        int         pick;
        string      punct;
        punct = " \n-!?%/.,;:'()[]";
        fb_values[0] = 8'h00;
        fb_values[1] = 8'hFF;
        fb_values[2] = 8'($urandom_range(2, 254));
        fb_values[3] = 8'h01;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, fallback at its reset value
        add_text("azAZ09 ");
        add_item(8'hE7, 1'b1, 1'b0);
        add_item(8'h00, 1'b1, 1'b0);
        add_item(8'hFF, 1'b1, 1'b0);
        add_item(CH_BRACE_CLOSE, 1'b1, 1'b0);
        add_item(8'h5A, 1'b0, 1'b0);
        add_text("{0x4a}");
        add_text("{0xF{");
        add_item(8'hA5, 1'b0, 1'b1);
        add_text("{0");
        add_item(CH_X_LOWER, 1'b1, 1'b1);
        wait_drained();

        foreach (fb_values[k]) begin
            @(posedge i_clk);
            i_cfg_wr_en   <= 1'b1;
            i_cfg_wr_data <= fb_values[k];
            fb_code = fb_values[k];
            @(posedge i_clk);
            i_cfg_wr_en   <= 1'b0;

            target = item_count + PHASE_ITEMS;
            while (item_count < target) begin
                pick = $urandom_range(0, 11);
                case (pick)
                    0, 1, 2, 3: begin
                        add_text("{0x");
                        add_item(rand_hex_char(), 1'b1, 1'b0);
                        add_item(rand_hex_char(), 1'b1, 1'b0);
                        add_item(CH_BRACE_CLOSE, 1'b1, $urandom_range(0, 5) == 0);
                    end
                    4, 5: begin
                        // escape broken after a random prefix
                        len = $urandom_range(1, 5);
                        add_item(CH_BRACE_OPEN, 1'b1, 1'b0);
                        if (len >= 2) add_item(CH_ZERO, 1'b1, 1'b0);
                        if (len >= 3) add_item(CH_X_LOWER, 1'b1, 1'b0);
                        if (len >= 4) add_item(rand_hex_char(), 1'b1, 1'b0);
                        if (len >= 5) add_item(rand_hex_char(), 1'b1, 1'b0);
                        case ($urandom_range(0, 3))
                            0: add_item(CH_BRACE_OPEN, 1'b1, 1'b0);
                            1: add_item(8'($urandom), 1'b0, 1'b1);
                            default: add_item(8'($urandom), 1'b1, $urandom_range(0, 3) == 0);
                        endcase
                    end
                    6, 7: begin
                        len = $urandom_range(1, 6);
                        for (int i = 0; i < len; i++) begin
                            case ($urandom_range(0, 4))
                                0: add_item(8'($urandom_range("a", "z")), 1'b1, 1'b0);
                                1: add_item(8'($urandom_range("A", "Z")), 1'b1, 1'b0);
                                2: add_item(8'($urandom_range("0", "9")), 1'b1, 1'b0);
                                3: add_item(punct[$urandom_range(0, punct.len() - 1)],
                                            1'b1, 1'b0);
                                default: add_item(8'($urandom_range(8'hA0, 8'hFF)),
                                                  1'b1, 1'b0);
                            endcase
                        end
                    end
                    8, 9: add_item(8'($urandom), 1'b1, 1'b0);
                    10: add_item(8'($urandom), 1'($urandom), 1'b1);
                    default: add_item(8'($urandom), 1'b0, 1'b0);
                endcase
            end
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
